// ===== design/sjq_pkg.sv =====
// Shared constants and types for the stable priority job queue.
package sjq_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam int TAG_W = 16;
    localparam int PRIO_W = 8;
    localparam int SERIAL_W = 32;
    localparam int STATUS_W = 2;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REMOVED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd3;

    typedef struct packed {
        logic load;
        logic ins;
        logic rem;
        logic report;
        logic [STATUS_W-1:0] code;
    } ctrl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } dp_status_t;

endpackage

// ===== design/sjq_ctrl.sv =====
// Controller: sequences accept and execute steps for each command beat.
module sjq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               command,
    input  sjq_pkg::dp_status_t dp_status,
    output logic               busy,
    output sjq_pkg::ctrl_t     ctrl
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic cmd_reg;
    logic cmd_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cmd_reg <= sjq_pkg::CMD_INSERT;
        end
        else
        begin
            state_reg <= state_next;
            cmd_reg <= cmd_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next = cmd_reg;
        ctrl = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctrl.load = 1'b1;
                    cmd_next = command;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                ctrl.report = 1'b1;
                if (cmd_reg == sjq_pkg::CMD_INSERT)
                begin
                    if (dp_status.full)
                    begin
                        ctrl.code = sjq_pkg::ST_FULL;
                    end
                    else
                    begin
                        ctrl.ins = 1'b1;
                        ctrl.code = sjq_pkg::ST_INSERTED;
                    end
                end
                else
                begin
                    if (dp_status.empty)
                    begin
                        ctrl.code = sjq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        ctrl.rem = 1'b1;
                        ctrl.code = sjq_pkg::ST_REMOVED;
                    end
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== design/sjq_datapath.sv =====
// Datapath: sorted shift-register chain of jobs, occupancy, serial and result registers.
module sjq_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sjq_pkg::ctrl_t                    ctrl,
    input  logic [sjq_pkg::TAG_W-1:0]         user_tag,
    input  logic [sjq_pkg::TAG_W-1:0]         doc_tag,
    input  logic [sjq_pkg::PRIO_W-1:0]        job_priority,
    output sjq_pkg::dp_status_t               dp_status,
    output logic                              done,
    output logic [sjq_pkg::STATUS_W-1:0]      status,
    output logic [sjq_pkg::TAG_W-1:0]         out_user_tag,
    output logic [sjq_pkg::TAG_W-1:0]         out_doc_tag,
    output logic [sjq_pkg::PRIO_W-1:0]        out_priority,
    output logic [sjq_pkg::SERIAL_W-1:0]      serial
);

    logic [sjq_pkg::TAG_W-1:0]    user_reg [sjq_pkg::DEPTH];
    logic [sjq_pkg::TAG_W-1:0]    user_next [sjq_pkg::DEPTH];
    logic [sjq_pkg::TAG_W-1:0]    doc_reg [sjq_pkg::DEPTH];
    logic [sjq_pkg::TAG_W-1:0]    doc_next [sjq_pkg::DEPTH];
    logic [sjq_pkg::PRIO_W-1:0]   prio_reg [sjq_pkg::DEPTH];
    logic [sjq_pkg::PRIO_W-1:0]   prio_next [sjq_pkg::DEPTH];
    logic [sjq_pkg::DEPTH-1:0]    keep;

    logic [sjq_pkg::TAG_W-1:0]    in_user_reg;
    logic [sjq_pkg::TAG_W-1:0]    in_doc_reg;
    logic [sjq_pkg::PRIO_W-1:0]   in_prio_reg;

    logic [sjq_pkg::OCC_W-1:0]    occ_reg;
    logic [sjq_pkg::OCC_W-1:0]    occ_next;
    logic [sjq_pkg::SERIAL_W-1:0] serial_cnt_reg;
    logic [sjq_pkg::SERIAL_W-1:0] serial_cnt_next;

    logic                         done_reg;
    logic [sjq_pkg::STATUS_W-1:0] status_reg;
    logic [sjq_pkg::TAG_W-1:0]    out_user_reg;
    logic [sjq_pkg::TAG_W-1:0]    out_doc_reg;
    logic [sjq_pkg::PRIO_W-1:0]   out_prio_reg;
    logic [sjq_pkg::SERIAL_W-1:0] out_serial_reg;

    assign dp_status.full = (occ_reg == sjq_pkg::OCC_W'(sjq_pkg::DEPTH));
    assign dp_status.empty = (occ_reg == '0);

    // keep flags form a prefix because the chain is sorted
    always_comb
    begin
        for (int i = 0; i < sjq_pkg::DEPTH; i++)
        begin
            keep[i] = (sjq_pkg::OCC_W'(i) < occ_reg) && (prio_reg[i] >= in_prio_reg);
        end
    end

    always_comb
    begin
        for (int i = 0; i < sjq_pkg::DEPTH; i++)
        begin
            user_next[i] = user_reg[i];
            doc_next[i] = doc_reg[i];
            prio_next[i] = prio_reg[i];
            if (ctrl.ins && !keep[i])
            begin
                if (i == 0 || keep[(i == 0) ? 0 : i - 1])
                begin
                    user_next[i] = in_user_reg;
                    doc_next[i] = in_doc_reg;
                    prio_next[i] = in_prio_reg;
                end
                else
                begin
                    user_next[i] = user_reg[(i == 0) ? 0 : i - 1];
                    doc_next[i] = doc_reg[(i == 0) ? 0 : i - 1];
                    prio_next[i] = prio_reg[(i == 0) ? 0 : i - 1];
                end
            end
            else if (ctrl.rem && i < sjq_pkg::DEPTH - 1)
            begin
                user_next[i] = user_reg[(i < sjq_pkg::DEPTH - 1) ? i + 1 : i];
                doc_next[i] = doc_reg[(i < sjq_pkg::DEPTH - 1) ? i + 1 : i];
                prio_next[i] = prio_reg[(i < sjq_pkg::DEPTH - 1) ? i + 1 : i];
            end
        end
    end

    always_comb
    begin
        occ_next = occ_reg;
        serial_cnt_next = serial_cnt_reg;
        if (ctrl.ins)
        begin
            occ_next = occ_reg + 1'b1;
        end
        else if (ctrl.rem)
        begin
            occ_next = occ_reg - 1'b1;
            serial_cnt_next = serial_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < sjq_pkg::DEPTH; i++)
        begin
            user_reg[i] <= user_next[i];
            doc_reg[i] <= doc_next[i];
            prio_reg[i] <= prio_next[i];
        end
        if (ctrl.load)
        begin
            in_user_reg <= user_tag;
            in_doc_reg <= doc_tag;
            in_prio_reg <= job_priority;
        end
        if (ctrl.report)
        begin
            status_reg <= ctrl.code;
            out_user_reg <= ctrl.rem ? user_reg[0] : '0;
            out_doc_reg <= ctrl.rem ? doc_reg[0] : '0;
            out_prio_reg <= ctrl.rem ? prio_reg[0] : '0;
            out_serial_reg <= ctrl.rem ? serial_cnt_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
            serial_cnt_reg <= sjq_pkg::SERIAL_W'(1);
            done_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
            serial_cnt_reg <= serial_cnt_next;
            done_reg <= ctrl.report;
        end
    end

    assign done = done_reg;
    assign status = status_reg;
    assign out_user_tag = out_user_reg;
    assign out_doc_tag = out_doc_reg;
    assign out_priority = out_prio_reg;
    assign serial = out_serial_reg;

endmodule

// ===== design/stable_priority_job_queue.sv =====
// Top level of the stable priority job queue: controller plus sorted-chain datapath.
// An accepted command enters the execute state, which loads the result registers on the ports.
// A new command is taken only while idle; the sorted chain inserts or shifts in one step.
// busy is high for the single execute cycle; the next command is taken while a result shows.
// Results appear for one cycle with done high; the receiver cannot stall them.
// Reset (rst_n low, asynchronous) empties the queue and sets the next serial to 1.
module stable_priority_job_queue (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              command,
    input  logic [sjq_pkg::TAG_W-1:0]         user_tag,
    input  logic [sjq_pkg::TAG_W-1:0]         doc_tag,
    input  logic [sjq_pkg::PRIO_W-1:0]        job_priority,
    output logic                              done,
    output logic [sjq_pkg::STATUS_W-1:0]      status,
    output logic [sjq_pkg::TAG_W-1:0]         out_user_tag,
    output logic [sjq_pkg::TAG_W-1:0]         out_doc_tag,
    output logic [sjq_pkg::PRIO_W-1:0]        out_priority,
    output logic [sjq_pkg::SERIAL_W-1:0]      serial
);

    sjq_pkg::ctrl_t      ctrl;
    sjq_pkg::dp_status_t dp_status;

    sjq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .command   (command),
        .dp_status (dp_status),
        .busy      (busy),
        .ctrl      (ctrl)
    );

    sjq_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .user_tag     (user_tag),
        .doc_tag      (doc_tag),
        .job_priority (job_priority),
        .dp_status    (dp_status),
        .done         (done),
        .status       (status),
        .out_user_tag (out_user_tag),
        .out_doc_tag  (out_doc_tag),
        .out_priority (out_priority),
        .serial       (serial)
    );

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted beat did not raise busy");

    a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy && done)
        else $error("execute step did not finish in one cycle");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");

    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != sjq_pkg::ST_REMOVED |->
            out_user_tag == '0 && out_doc_tag == '0 && out_priority == '0 && serial == '0)
        else $error("nonzero fields on a result without a removed job");

endmodule
